// File: hw/rtl/rne_pkg.sv
// Package for the Roman numeral encoder: state and control types, status codes,
// ASCII letter codes and the digit pattern functions.
// No dependencies.
package rne_pkg;

  // Field widths
  localparam int unsigned ValueW  = 16;
  localparam int unsigned LetterW = 7;
  localparam int unsigned StatusW = 2;

  // Values 1..3999 fit in 12 bits; four BCD digits hold the conversion
  localparam int unsigned BinW    = 12;
  localparam int unsigned BcdW    = 16;
  localparam int unsigned BitCntW = 4;
  localparam logic [ValueW-1:0] ValueLimit = ValueW'(3999);

  // Result status codes
  localparam logic [StatusW-1:0] STATUS_OK   = 2'd0;
  localparam logic [StatusW-1:0] STATUS_ZERO = 2'd1;
  localparam logic [StatusW-1:0] STATUS_OVER = 2'd2;

  // ASCII letters
  localparam logic [LetterW-1:0] ASCII_I = 7'h49;
  localparam logic [LetterW-1:0] ASCII_V = 7'h56;
  localparam logic [LetterW-1:0] ASCII_X = 7'h58;
  localparam logic [LetterW-1:0] ASCII_L = 7'h4C;
  localparam logic [LetterW-1:0] ASCII_C = 7'h43;
  localparam logic [LetterW-1:0] ASCII_D = 7'h44;
  localparam logic [LetterW-1:0] ASCII_M = 7'h4D;
  localparam logic [LetterW-1:0] ASCII_NUL = 7'h00;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT,
    ST_ERR
  } state_e;

  // Position of a letter within its letter set
  typedef enum logic [1:0] {
    SEL_ONE,
    SEL_FIVE,
    SEL_TEN
  } sel_e;

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture the input value and classify it
    logic dabble;    // one binary-to-BCD shift step
    logic step;      // emit the current letter (if any) and advance
    logic emit_err;  // emit the single error result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_bad;     // input value is zero or above the limit
    logic conv_done;  // this dabble step is the final one
    logic out_busy;   // output register holds a result not taken this cycle
    logic is_last;    // current letter closes the numeral
  } sts_t;

  // Number of letters for one decimal digit
  function automatic logic [2:0] rn_len(input logic [3:0] d);
    logic [2:0] len;
    case (d)
      4'd0:    len = 3'd0;
      4'd1:    len = 3'd1;
      4'd2:    len = 3'd2;
      4'd3:    len = 3'd3;
      4'd4:    len = 3'd2;
      4'd5:    len = 3'd1;
      4'd6:    len = 3'd2;
      4'd7:    len = 3'd3;
      4'd8:    len = 3'd4;
      4'd9:    len = 3'd2;
      default: len = 3'd0;
    endcase
    return len;
  endfunction

  // Which letter of the set stands at position j of digit d
  function automatic sel_e rn_sel(input logic [3:0] d, input logic [1:0] j);
    sel_e sel;
    if (d == 4'd9) begin
      sel = (j == 2'd0) ? SEL_ONE : SEL_TEN;
    end else if (d >= 4'd5) begin
      sel = (j == 2'd0) ? SEL_FIVE : SEL_ONE;
    end else if (d == 4'd4) begin
      sel = (j == 2'd0) ? SEL_ONE : SEL_FIVE;
    end else begin
      sel = SEL_ONE;
    end
    return sel;
  endfunction

  // Letter for decimal place p (0 = units) and set position
  function automatic logic [LetterW-1:0] rn_letter(input logic [1:0] p, input sel_e sel);
    logic [LetterW-1:0] ch;
    case (p)
      2'd0: begin
        case (sel)
          SEL_ONE:  ch = ASCII_I;
          SEL_FIVE: ch = ASCII_V;
          SEL_TEN:  ch = ASCII_X;
          default:  ch = ASCII_I;
        endcase
      end
      2'd1: begin
        case (sel)
          SEL_ONE:  ch = ASCII_X;
          SEL_FIVE: ch = ASCII_L;
          SEL_TEN:  ch = ASCII_C;
          default:  ch = ASCII_X;
        endcase
      end
      2'd2: begin
        case (sel)
          SEL_ONE:  ch = ASCII_C;
          SEL_FIVE: ch = ASCII_D;
          SEL_TEN:  ch = ASCII_M;
          default:  ch = ASCII_C;
        endcase
      end
      default: ch = ASCII_M;  // thousands: only M is ever used
    endcase
    return ch;
  endfunction

endpackage

// File: hw/rtl/rne_datapath.sv
// Datapath of the Roman numeral encoder: value capture, shift-add-3 BCD
// conversion, digit/letter walk and the output register. Uses rne_pkg.
module rne_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [rne_pkg::ValueW-1:0]   value_i,
  input  rne_pkg::cmd_t                cmd_i,
  output rne_pkg::sts_t                sts_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [rne_pkg::LetterW-1:0]  letter_o,
  output logic                         last_o,
  output logic [rne_pkg::StatusW-1:0]  status_o
);

  logic [rne_pkg::BinW-1:0]    bin_q;
  logic [rne_pkg::BcdW-1:0]    bcd_q, bcd_adj;
  logic [rne_pkg::BitCntW-1:0] cnt_q;
  logic [1:0]                  place_q;
  logic [1:0]                  pos_q;
  logic [rne_pkg::StatusW-1:0] err_q;

  logic                        out_valid_q;
  logic [rne_pkg::LetterW-1:0] letter_q;
  logic                        last_q;
  logic [rne_pkg::StatusW-1:0] status_q;

  logic                        in_zero, in_over;
  logic [3:0]                  digit;
  logic [2:0]                  dig_len;
  logic                        dig_end;
  logic                        lower_zero;
  rne_pkg::sel_e               sel;

  // Input classification
  assign in_zero = (value_i == '0);
  assign in_over = (value_i > rne_pkg::ValueLimit);

  // Add 3 to every BCD digit of 5 or more before the shift
  always_comb begin
    for (int k = 0; k < rne_pkg::BcdW / 4; k++) begin
      bcd_adj[k*4 +: 4] = (bcd_q[k*4 +: 4] >= 4'd5) ? bcd_q[k*4 +: 4] + 4'd3
                                                    : bcd_q[k*4 +: 4];
    end
  end

  // Current digit and its letter pattern
  assign digit   = bcd_q[place_q*4 +: 4];
  assign dig_len = rne_pkg::rn_len(digit);
  assign dig_end = ({1'b0, pos_q} + 3'd1) == dig_len;
  assign sel     = rne_pkg::rn_sel(digit, pos_q);

  // All digits below the current place are zero
  always_comb begin
    case (place_q)
      2'd3:    lower_zero = (bcd_q[11:0] == '0);
      2'd2:    lower_zero = (bcd_q[7:0] == '0);
      2'd1:    lower_zero = (bcd_q[3:0] == '0);
      default: lower_zero = 1'b1;
    endcase
  end

  // Conversion and walk registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bin_q   <= value_i[rne_pkg::BinW-1:0];
      bcd_q   <= '0;
      cnt_q   <= '0;
      place_q <= 2'd3;
      pos_q   <= 2'd0;
      err_q   <= in_zero ? rne_pkg::STATUS_ZERO : rne_pkg::STATUS_OVER;
    end else if (cmd_i.dabble) begin
      {bcd_q, bin_q} <= {bcd_adj[rne_pkg::BcdW-2:0], bin_q, 1'b0};
      cnt_q          <= cnt_q + 1'b1;
    end else if (cmd_i.step) begin
      if (dig_len == 3'd0 || dig_end) begin
        place_q <= place_q - 1'b1;
        pos_q   <= 2'd0;
      end else begin
        pos_q <= pos_q + 1'b1;
      end
    end
  end

  // Output register valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_err || (cmd_i.step && dig_len != 3'd0)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_err) begin
      letter_q <= rne_pkg::ASCII_NUL;
      last_q   <= 1'b1;
      status_q <= err_q;
    end else if (cmd_i.step && dig_len != 3'd0) begin
      letter_q <= rne_pkg::rn_letter(place_q, sel);
      last_q   <= dig_end && lower_zero;
      status_q <= rne_pkg::STATUS_OK;
    end
  end

  assign sts_o.in_bad    = in_zero || in_over;
  assign sts_o.conv_done = (cnt_q == rne_pkg::BitCntW'(rne_pkg::BinW - 1));
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;
  assign sts_o.is_last   = (dig_len != 3'd0) && dig_end && lower_zero;

  assign out_valid_o = out_valid_q;
  assign letter_o    = letter_q;
  assign last_o      = last_q;
  assign status_o    = status_q;

endmodule

// File: hw/rtl/rne_ctrl.sv
// Controller of the Roman numeral encoder: sequences capture, BCD conversion
// and the letter walk. Uses rne_pkg.
module rne_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rne_pkg::sts_t sts_i,
  output rne_pkg::cmd_t cmd_o
);

  rne_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rne_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rne_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = sts_i.in_bad ? rne_pkg::ST_ERR : rne_pkg::ST_CONV;
        end
      end
      rne_pkg::ST_CONV: begin
        if (sts_i.conv_done) state_d = rne_pkg::ST_EMIT;
      end
      rne_pkg::ST_EMIT: begin
        if (!sts_i.out_busy && sts_i.is_last) state_d = rne_pkg::ST_IDLE;
      end
      rne_pkg::ST_ERR: begin
        if (!sts_i.out_busy) state_d = rne_pkg::ST_IDLE;
      end
      default: state_d = rne_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      rne_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      rne_pkg::ST_CONV: cmd_o.dabble   = 1'b1;
      rne_pkg::ST_EMIT: cmd_o.step     = !sts_i.out_busy;
      rne_pkg::ST_ERR:  cmd_o.emit_err = !sts_i.out_busy;
      default: ;
    endcase
  end

endmodule

// File: hw/rtl/roman_numeral_encoder.sv
// Roman numeral encoder: converts one unsigned number into a stream of ASCII
// Roman letters, one letter per output transfer, most significant digit first.
// Channels: input value (in_valid_i/in_ready_o), output letter/last/status
// (out_valid_o/out_ready_i). last_o marks the final transfer of a numeral.
// A value of zero gives one transfer with status 1, a value above 3999 one
// transfer with status 2; both carry letter 0 and last set.
// Sequence: an item is taken in idle, then shift-add-3 conversion of its
// 12 bits (one input bit per cycle), then the letter walk, which emits the
// letters in order and steps over each zero digit before the final letter
// (3888 gives 15 letters). Out-of-range and zero values go from idle
// straight to the error result. One item is in work at a time; the next is
// taken as soon as the controller is back in idle, even while the final
// result still sits in the output register.
// A stalled receiver holds the output register and the letter walk waits.
// Reset empties the output register and returns the controller to idle.
// Depends on rne_pkg, rne_ctrl and rne_datapath.
module roman_numeral_encoder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [rne_pkg::ValueW-1:0]   value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [rne_pkg::LetterW-1:0]  letter_o,
  output logic                         last_o,
  output logic [rne_pkg::StatusW-1:0]  status_o
);

  rne_pkg::cmd_t cmd;
  rne_pkg::sts_t sts;

  // Sequencer
  rne_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Conversion and output path
  rne_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (value_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .letter_o    (letter_o),
    .last_o      (last_o),
    .status_o    (status_o)
  );

endmodule
